/* design/mwm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package mwm_pkg;

	localparam int NumWheels = 4;
	localparam int MixQBits  = 15;
	localparam int DutyQBits = 8;

	typedef enum logic [1:0] {
		MODE_MIX    = 2'd0,
		MODE_DIRECT = 2'd1,
		MODE_STOP   = 2'd2,
		MODE_STOP_X = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		DIR_OFF = 2'd0,
		DIR_FWD = 2'd1,
		DIR_REV = 2'd2
	} dir_t;

	typedef enum logic [1:0] {
		REG_LIMIT_HIGH = 2'd0,
		REG_LIMIT_LOW  = 2'd1,
		REG_PWM_FULL   = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]         mode;
		logic signed [15:0] lateral_cmd;
		logic signed [15:0] forward_cmd;
		logic signed [15:0] rotation_cmd;
		logic signed [15:0] front_left_cmd;
		logic signed [15:0] front_right_cmd;
		logic signed [15:0] rear_left_cmd;
		logic signed [15:0] rear_right_cmd;
	} cmd_t;

	typedef struct packed {
		logic [1:0] front_left_dir;
		logic [7:0] front_left_duty;
		logic [1:0] front_right_dir;
		logic [7:0] front_right_duty;
		logic [1:0] rear_left_dir;
		logic [7:0] rear_left_duty;
		logic [1:0] rear_right_dir;
		logic [7:0] rear_right_duty;
	} result_t;

	// one stage of the normalization divider
	typedef struct packed {
		mode_t                                mode;
		logic [NumWheels-1:0]                 neg;
		logic [NumWheels-1:0][15:0]           dval;
		logic [NumWheels-1:0][31:0]           rem;
		logic [NumWheels-1:0][MixQBits-1:0]   quo;
		logic [16:0]                          mx;
	} mdiv_t;

	// one stage of the duty divider
	typedef struct packed {
		mode_t                                mode;
		logic [NumWheels-1:0]                 neg;
		logic [NumWheels-1:0]                 sat;
		logic [NumWheels-1:0][23:0]           rem;
		logic [NumWheels-1:0][DutyQBits-1:0]  quo;
	} ddiv_t;

endpackage
`default_nettype wire

/* design/mecanum_wheel_mixer.sv */
`timescale 1ns / 1ps
`default_nettype none
// Mecanum wheel mixer, fully pipelined.
// Registers start to done: stages 1-3, the 15-stage normalization divider, E1,
// E2, the 8-stage duty divider and output register; one quotient bit per stage.
// Throughput: one item per cycle; busy stays low, the receiver cannot stall.
// Reset: arst_n clears all valid bits and loads limits 1000 / -1000 and duty 255.
module mecanum_wheel_mixer import mwm_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire cmd_t        cmd,
	output logic             done,
	output result_t          result,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	// configuration registers
	logic [14:0]        limit_high_q;
	logic signed [15:0] limit_low_q;
	logic [7:0]         pwm_full_q;
	logic [14:0]        hi;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_high_q <= 15'd1000;
			limit_low_q  <= -16'sd1000;
			pwm_full_q   <= 8'd255;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_LIMIT_HIGH: limit_high_q <= cfg_data[14:0];
				REG_LIMIT_LOW:  limit_low_q  <= cfg_data;
				REG_PWM_FULL:   pwm_full_q   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// a zero upper limit behaves as one everywhere
	assign hi   = (limit_high_q == 15'd0) ? 15'd1 : limit_high_q;
	assign busy = 1'b0;

	// with crossed limits the upper clamp wins only for values above the upper limit
	function automatic logic [15:0] clamp(input logic [15:0] v, input logic [14:0] h,
			input logic [15:0] l);
		logic [15:0] r;
		if ($signed(v) > $signed({1'b0, h}))
			r = {1'b0, h};
		else if ($signed(v) < $signed(l))
			r = l;
		else
			r = v;
		return r;
	endfunction

	// ---- stage 1: capture and clamp -------------------------------------
	logic                       vld_s1;
	mode_t                      mode_s1;
	logic [NumWheels-1:0][15:0] val_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else         vld_s1 <= start;
	end

	always_ff @(posedge clk) begin
		mode_s1 <= mode_t'(cmd.mode);
		if (cmd.mode == MODE_MIX) begin
			val_s1[0] <= clamp(cmd.lateral_cmd, hi, limit_low_q);
			val_s1[1] <= clamp(cmd.forward_cmd, hi, limit_low_q);
			val_s1[2] <= clamp(cmd.rotation_cmd, hi, limit_low_q);
			val_s1[3] <= 16'd0;
		end else begin
			val_s1[0] <= clamp(cmd.front_left_cmd, hi, limit_low_q);
			val_s1[1] <= clamp(cmd.front_right_cmd, hi, limit_low_q);
			val_s1[2] <= clamp(cmd.rear_left_cmd, hi, limit_low_q);
			val_s1[3] <= clamp(cmd.rear_right_cmd, hi, limit_low_q);
		end
	end

	// ---- stage 2: wheel sums and magnitudes -----------------------------
	logic                       vld_s2;
	mode_t                      mode_s2;
	logic [NumWheels-1:0][15:0] dval_s2;
	logic [NumWheels-1:0]       neg_s2;
	logic [NumWheels-1:0][16:0] mag_s2;
	logic signed [17:0]         x_ext, y_ext, r_ext;
	logic signed [17:0]         wsum [NumWheels];

	assign x_ext = {{2{val_s1[0][15]}}, val_s1[0]};
	assign y_ext = {{2{val_s1[1][15]}}, val_s1[1]};
	assign r_ext = {{2{val_s1[2][15]}}, val_s1[2]};

	always_comb begin
		wsum[0] = y_ext + x_ext + r_ext;
		wsum[1] = y_ext - x_ext - r_ext;
		wsum[2] = y_ext - x_ext + r_ext;
		wsum[3] = y_ext + x_ext - r_ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else         vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		mode_s2 <= mode_s1;
		dval_s2 <= val_s1;
		for (int w = 0; w < NumWheels; w++) begin
			neg_s2[w] <= wsum[w][17];
			mag_s2[w] <= wsum[w][17] ? 17'(-wsum[w]) : wsum[w][16:0];
		end
	end

	// ---- stage 3: largest magnitude (at least hi) and scaled numerators ---
	logic [16:0] mx_c;
	logic        mvld_s [0:MixQBits];
	mdiv_t       mdiv_s [0:MixQBits];

	always_comb begin
		mx_c = {2'b0, hi};
		for (int w = 0; w < NumWheels; w++)
			if (mag_s2[w] > mx_c) mx_c = mag_s2[w];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mvld_s[0] <= 1'b0;
		else         mvld_s[0] <= vld_s2;
	end

	always_ff @(posedge clk) begin
		mdiv_s[0].mode <= mode_s2;
		mdiv_s[0].neg  <= neg_s2;
		mdiv_s[0].dval <= dval_s2;
		mdiv_s[0].mx   <= mx_c;
		mdiv_s[0].quo  <= '0;
		for (int w = 0; w < NumWheels; w++)
			mdiv_s[0].rem[w] <= 32'(mag_s2[w] * hi);
	end

	// ---- normalization divider: one quotient bit per stage --------------
	for (genvar k = 0; k < MixQBits; k++) begin : g_mdiv
		mdiv_t       nxt;
		logic [31:0] dsh;

		assign dsh = 32'(mdiv_s[k].mx) << (MixQBits - 1 - k);

		always_comb begin
			nxt = mdiv_s[k];
			for (int w = 0; w < NumWheels; w++) begin
				if (mdiv_s[k].rem[w] >= dsh) begin
					nxt.rem[w] = mdiv_s[k].rem[w] - dsh;
					nxt.quo[w][MixQBits-1-k] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) mvld_s[k+1] <= 1'b0;
			else         mvld_s[k+1] <= mvld_s[k];
		end

		always_ff @(posedge clk) begin
			mdiv_s[k+1] <= nxt;
		end
	end

	// ---- stage E1: pick wheel value and clamp again ---------------------
	logic                       vld_e1;
	mode_t                      mode_e1;
	logic [NumWheels-1:0][15:0] c_e1;
	logic [15:0]                wv [NumWheels];

	always_comb begin
		for (int w = 0; w < NumWheels; w++) begin
			if (mdiv_s[MixQBits].mode == MODE_MIX)
				wv[w] = mdiv_s[MixQBits].neg[w] ? 16'(-{1'b0, mdiv_s[MixQBits].quo[w]})
					: {1'b0, mdiv_s[MixQBits].quo[w]};
			else
				wv[w] = mdiv_s[MixQBits].dval[w];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_e1 <= 1'b0;
		else         vld_e1 <= mvld_s[MixQBits];
	end

	always_ff @(posedge clk) begin
		mode_e1 <= mdiv_s[MixQBits].mode;
		for (int w = 0; w < NumWheels; w++)
			c_e1[w] <= clamp(wv[w], hi, limit_low_q);
	end

	// ---- stage E2: duty numerator and saturation check ------------------
	logic        dvld_s [0:DutyQBits];
	ddiv_t       ddiv_s [0:DutyQBits];
	logic [16:0] cmag [NumWheels];
	logic [23:0] prod [NumWheels];

	always_comb begin
		for (int w = 0; w < NumWheels; w++) begin
			cmag[w] = c_e1[w][15] ? 17'(-{c_e1[w][15], c_e1[w]}) : {1'b0, c_e1[w]};
			prod[w] = 24'(cmag[w] * pwm_full_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dvld_s[0] <= 1'b0;
		else         dvld_s[0] <= vld_e1;
	end

	always_ff @(posedge clk) begin
		ddiv_s[0].mode <= mode_e1;
		ddiv_s[0].quo  <= '0;
		for (int w = 0; w < NumWheels; w++) begin
			ddiv_s[0].neg[w] <= c_e1[w][15];
			ddiv_s[0].sat[w] <= prod[w] >= {1'b0, hi, 8'b0};
			ddiv_s[0].rem[w] <= prod[w];
		end
	end

	// ---- duty divider: quotient fits in eight bits unless saturated -----
	for (genvar k = 0; k < DutyQBits; k++) begin : g_ddiv
		ddiv_t       nxt;
		logic [23:0] dsh;

		assign dsh = 24'(hi) << (DutyQBits - 1 - k);

		always_comb begin
			nxt = ddiv_s[k];
			for (int w = 0; w < NumWheels; w++) begin
				if (!ddiv_s[k].sat[w] && ddiv_s[k].rem[w] >= dsh) begin
					nxt.rem[w] = ddiv_s[k].rem[w] - dsh;
					nxt.quo[w][DutyQBits-1-k] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dvld_s[k+1] <= 1'b0;
			else         dvld_s[k+1] <= dvld_s[k];
		end

		always_ff @(posedge clk) begin
			ddiv_s[k+1] <= nxt;
		end
	end

	// ---- output register ------------------------------------------------
	logic [7:0] duty_c [NumWheels];
	logic [1:0] dir_c  [NumWheels];
	logic       stop_c;

	always_comb begin
		stop_c = (ddiv_s[DutyQBits].mode == MODE_STOP) ||
			(ddiv_s[DutyQBits].mode == MODE_STOP_X);
		for (int w = 0; w < NumWheels; w++) begin
			duty_c[w] = ddiv_s[DutyQBits].sat[w] ? 8'd255 : ddiv_s[DutyQBits].quo[w];
			if (stop_c) duty_c[w] = 8'd0;
			if (duty_c[w] == 8'd0)
				dir_c[w] = DIR_OFF;
			else if (ddiv_s[DutyQBits].neg[w])
				dir_c[w] = DIR_REV;
			else
				dir_c[w] = DIR_FWD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else         done <= dvld_s[DutyQBits];
	end

	always_ff @(posedge clk) begin
		result.front_left_dir   <= dir_c[0];
		result.front_left_duty  <= duty_c[0];
		result.front_right_dir  <= dir_c[1];
		result.front_right_duty <= duty_c[1];
		result.rear_left_dir    <= dir_c[2];
		result.rear_left_duty   <= duty_c[2];
		result.rear_right_dir   <= dir_c[3];
		result.rear_right_duty  <= duty_c[3];
	end

endmodule
`default_nettype wire
